FILE: sv/swrl_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the control program of the rate limiter
// no dependencies
package swrl_pkg;

    localparam int KEY_W  = 6;
    localparam int NOW_W  = 32;
    localparam int CNT_W  = 5;
    localparam int MAXR_W = 5;
    localparam int WIN_W  = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MAX_REQUESTS = cfg_idx_t'(0);
    localparam cfg_idx_t REG_WINDOW_LEN   = cfg_idx_t'(1);

    localparam logic [MAXR_W-1:0] MAX_REQUESTS_RST = MAXR_W'(10);
    localparam logic [WIN_W-1:0]  WINDOW_LEN_RST   = WIN_W'(1000);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_META,
        S_LOAD,
        S_RD,
        S_CHK,
        S_DEC,
        S_WB
    } step_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_CLR_DONE,
        COND_SCAN_STOP,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  load_meta;
        logic  scan;
        logic  decide;
        logic  meta_wr;
        logic  emit;
        logic  clear;
        cond_t cond;
        step_t target;
    } uop_t;

    typedef struct packed {
        logic in_valid;
        logic clr_done;
        logic scan_stop;
        logic out_free;
    } cond_flags_t;

    typedef struct packed {
        logic clr_done;
        logic scan_stop;
    } dp_stat_t;

    // control store: jump to target when the condition holds, else stay
    function automatic uop_t ucode(input step_t s);
        uop_t u;
        u = '0;
        unique case (s)
            S_CLEAR:
            begin
                u.clear  = 1'b1;
                u.cond   = COND_CLR_DONE;
                u.target = S_IDLE;
            end
            S_IDLE:
            begin
                u.take_in = 1'b1;
                u.cond    = COND_IN_VALID;
                u.target  = S_META;
            end
            S_META:
            begin
                u.cond   = COND_ALWAYS;
                u.target = S_LOAD;
            end
            S_LOAD:
            begin
                u.load_meta = 1'b1;
                u.cond      = COND_ALWAYS;
                u.target    = S_RD;
            end
            S_RD:
            begin
                u.cond   = COND_ALWAYS;
                u.target = S_CHK;
            end
            S_CHK:
            begin
                u.scan   = 1'b1;
                u.cond   = COND_SCAN_STOP;
                u.target = S_DEC;
            end
            S_DEC:
            begin
                u.decide = 1'b1;
                u.cond   = COND_ALWAYS;
                u.target = S_WB;
            end
            S_WB:
            begin
                u.meta_wr = 1'b1;
                u.emit    = 1'b1;
                u.cond    = COND_OUT_FREE;
                u.target  = S_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

FILE: sv/swrl_req_if.sv
`timescale 1ns / 1ps
// request channel: key index and timestamp with valid/ready
// depends on swrl_pkg
interface swrl_req_if import swrl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_index;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, output key_index, output now_ms, input ready);
    modport sink (input valid, input key_index, input now_ms, output ready);
endinterface

FILE: sv/swrl_res_if.sv
`timescale 1ns / 1ps
// result channel: limited flag and window count with valid/ready
// depends on swrl_pkg
interface swrl_res_if import swrl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             limited;
    logic [CNT_W-1:0] window_count;

    modport source (output valid, output limited, output window_count, input ready);
    modport sink (input valid, input limited, input window_count, output ready);
endinterface

FILE: sv/swrl_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel: register index and data with valid/ready
// depends on swrl_pkg
interface swrl_cfg_if import swrl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/swrl_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/swrl_useq.sv
`timescale 1ns / 1ps
// microcode sequencer: step register, control store lookup, conditional jumps
// depends on swrl_pkg
module swrl_useq import swrl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cond_flags_t flags,
    output uop_t        uop
);

    step_t upc_reg;
    step_t upc_next;
    logic  taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_comb
    begin
        uop = ucode(upc_reg);
        unique case (uop.cond)
            COND_ALWAYS:    taken = 1'b1;
            COND_IN_VALID:  taken = flags.in_valid;
            COND_CLR_DONE:  taken = flags.clr_done;
            COND_SCAN_STOP: taken = flags.scan_stop;
            COND_OUT_FREE:  taken = flags.out_free;
            default:        taken = 1'b0;
        endcase
        upc_next = taken ? uop.target : upc_reg;
    end

    a_no_take_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg == S_CLEAR |-> !uop.take_in)
        else $error("request taken during clearing pass");

    a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == S_IDLE && flags.in_valid) |=> upc_reg == S_META)
        else $error("accepted request did not start processing");

    a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == S_WB && flags.out_free) |=> upc_reg == S_IDLE)
        else $error("sequencer did not return to idle after result");

endmodule

FILE: sv/swrl_dpath.sv
`timescale 1ns / 1ps
// datapath: per-key head/count memory, timestamp memory, scan and append logic
// depends on swrl_pkg and swrl_ram
module swrl_dpath import swrl_pkg::*; #(
    parameter int KEYS      = 64,
    parameter int LOG_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  uop_t              uop,
    input  logic              in_valid,
    input  logic [KEY_W-1:0]  key_index,
    input  logic [NOW_W-1:0]  now_ms,
    input  logic [MAXR_W-1:0] max_requests,
    input  logic [WIN_W-1:0]  window_len,
    output dp_stat_t          stat,
    output logic              limited,
    output logic [CNT_W-1:0]  window_count
);

    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int HW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int XW = (CW > CNT_W) ? CW : CNT_W;
    localparam int MW = HW + CW;
    localparam int AW = KW + HW;

    // key modulo KEYS by restoring compare and subtract
    function automatic logic [KEY_W-1:0] key_mod(input logic [KEY_W-1:0] v);
        int r;
        r = int'(v);
        for (int i = KEY_W - 1; i >= 0; i--)
        begin
            if (r >= (KEYS << i))
            begin
                r = r - (KEYS << i);
            end
        end
        return KEY_W'(r);
    endfunction

    logic [KW-1:0]    key_reg;
    logic [NOW_W-1:0] now_reg;
    logic [HW-1:0]    head_reg;
    logic [CW-1:0]    count_reg;
    logic             limited_reg;
    logic [KW-1:0]    clr_idx_reg;

    logic [MW-1:0]    meta_rdata;
    logic [MW-1:0]    meta_wdata;
    logic [KW-1:0]    meta_waddr;
    logic             meta_we;
    logic [HW-1:0]    meta_head;
    logic [CW-1:0]    meta_count;

    logic [NOW_W-1:0] stamp_rdata;
    logic [AW-1:0]    stamp_raddr;
    logic [AW-1:0]    stamp_waddr;
    logic             stamp_we;

    logic [NOW_W-1:0] age;
    logic             pop;
    logic [HW-1:0]    head_inc;
    logic [SW-1:0]    slot_sum;
    logic [HW-1:0]    slot;
    logic             is_limited;
    logic [XW-1:0]    count_x;

    always_comb
    begin
        meta_head  = meta_rdata[MW-1:CW];
        meta_count = meta_rdata[CW-1:0];
        head_inc   = (head_reg == HW'(LOG_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        age        = now_reg - stamp_rdata;
        stat.scan_stop = (count_reg == '0) || (age < NOW_W'(window_len));
        stat.clr_done  = clr_idx_reg == KW'(KEYS - 1);
        pop        = uop.scan && !stat.scan_stop;
        slot_sum   = SW'(head_reg) + SW'(count_reg);
        slot       = (slot_sum >= SW'(LOG_DEPTH)) ? HW'(slot_sum - SW'(LOG_DEPTH))
                                                  : HW'(slot_sum);
        is_limited = (XW'(count_reg) >= XW'(max_requests)) || (count_reg >= CW'(LOG_DEPTH));
        stamp_raddr = {key_reg, (pop ? head_inc : head_reg)};
        stamp_waddr = {key_reg, slot};
        stamp_we    = uop.decide && !is_limited;
        meta_we     = uop.clear || uop.meta_wr;
        meta_waddr  = uop.clear ? clr_idx_reg : key_reg;
        meta_wdata  = uop.clear ? '0 : {head_reg, count_reg};
        count_x     = XW'(count_reg);
        limited      = limited_reg;
        window_count = count_x[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (uop.clear)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uop.take_in && in_valid)
        begin
            key_reg <= KW'(key_mod(key_index));
            now_reg <= now_ms;
        end
        if (uop.load_meta)
        begin
            head_reg  <= meta_head;
            count_reg <= (meta_count > CW'(LOG_DEPTH)) ? CW'(LOG_DEPTH) : meta_count;
        end
        else if (pop)
        begin
            head_reg  <= head_inc;
            count_reg <= count_reg - 1'b1;
        end
        else if (uop.decide)
        begin
            limited_reg <= is_limited;
            if (!is_limited)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    swrl_ram #(
        .WIDTH (MW),
        .DEPTH (KEYS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (key_reg),
        .rdata (meta_rdata)
    );

    swrl_ram #(
        .WIDTH (NOW_W),
        .DEPTH (2 ** AW)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (now_reg),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        uop.meta_wr |-> count_reg <= CW'(LOG_DEPTH))
        else $error("ring count beyond depth");

    a_accept_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (uop.meta_wr && !limited_reg) |-> count_reg != '0)
        else $error("accepted request left an empty ring");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("expired stamp pop did not shrink count");

endmodule

FILE: sv/sliding_window_rate_limiter.sv
`timescale 1ns / 1ps
// Sliding window log rate limiter. A request is accepted in the idle step and
// passes through the meta, load, read, check, decide and write-back steps before
// the next one can be taken; in the check step the timestamp memory's single read
// port scans one stamp per cycle, dropping the P (0 to LOG_DEPTH) expired stamps
// of that key, around a fixed read, decide and write-back of the per-key head/count
// entry. A result that is not taken holds the sequencer in its write-back step.
// After reset a clearing pass zeroes every key's count before the first request
// is taken; configuration writes are taken at any time.
// depends on swrl_pkg, the channel interfaces, swrl_useq and swrl_dpath
module sliding_window_rate_limiter import swrl_pkg::*; #(
    parameter int KEYS      = 64,
    parameter int LOG_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    swrl_req_if.sink   req,
    swrl_res_if.source res,
    swrl_cfg_if.sink   cfg
);

    logic [MAXR_W-1:0] max_reg;
    logic [WIN_W-1:0]  window_reg;
    logic              res_valid_reg;
    logic              res_limited_reg;
    logic [CNT_W-1:0]  res_count_reg;

    uop_t        uop;
    cond_flags_t flags;
    dp_stat_t    stat;
    logic        dp_limited;
    logic [CNT_W-1:0] dp_count;
    logic        out_load;

    always_comb
    begin
        flags.in_valid  = req.valid;
        flags.clr_done  = stat.clr_done;
        flags.scan_stop = stat.scan_stop;
        flags.out_free  = !res_valid_reg || res.ready;
        out_load        = uop.emit && flags.out_free;
        req.ready       = uop.take_in;
        cfg.ready       = 1'b1;
        res.valid        = res_valid_reg;
        res.limited      = res_limited_reg;
        res.window_count = res_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= MAX_REQUESTS_RST;
            window_reg <= WINDOW_LEN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_REQUESTS: max_reg    <= cfg.data[MAXR_W-1:0];
                REG_WINDOW_LEN:   window_reg <= cfg.data[WIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_limited_reg <= dp_limited;
            res_count_reg   <= dp_count;
        end
    end

    swrl_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uop   (uop)
    );

    swrl_dpath #(
        .KEYS      (KEYS),
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .uop          (uop),
        .in_valid     (req.valid),
        .key_index    (req.key_index),
        .now_ms       (req.now_ms),
        .max_requests (max_reg),
        .window_len   (window_reg),
        .stat         (stat),
        .limited      (dp_limited),
        .window_count (dp_count)
    );

endmodule
